[rtl/lcet_pkg.sv]
// Shared types and constants for the Li Chao line envelope tree.
// Used by the controller, the datapath and the top level.
`default_nettype none
package lcet_pkg;

  // Operation codes carried by a request
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic REG_MIN_MODE    = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;
  localparam int   CFG_WIDTH       = 11;

  // Coordinate table read selects
  localparam logic [1:0] CSEL_LO  = 2'd0;
  localparam logic [1:0] CSEL_HI  = 2'd1;
  localparam logic [1:0] CSEL_MID = 2'd2;

  // Insert evaluation steps: t at lo, t at hi, v at lo, v at hi, t at mid, v at mid
  localparam logic [2:0] EV_LAST = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         point_index;
    logic signed [31:0] point_value;
    logic signed [31:0] slope;
    logic signed [47:0] intercept;
    logic signed [31:0] query_point;
  } lcet_req_t;

  typedef struct packed {
    logic signed [63:0] envelope_value;
    logic               line_present;
  } lcet_rsp_t;

  typedef struct packed {
    logic       load_coord;
    logic       init;
    logic       clr_wr;
    logic       rd_node;
    logic       rd_coord;
    logic [1:0] coord_sel;
    logic       put_new;
    logic       latch_t;
    logic       latch_xr;
    logic       latch_xm;
    logic       mul_en;
    logic       add_en;
    logic [2:0] ev;
    logic       decide;
    logic       q_mul;
    logic       q_acc;
    logic       out_load;
  } lcet_cmd_t;

  typedef struct packed {
    logic used;
    logic clr_last;
    logic ins_stop;
    logic q_stop;
    logic out_free;
  } lcet_sts_t;

endpackage
`default_nettype wire

[rtl/li_chao_line_envelope_tree.sv]
// Top level of the Li Chao line envelope tree.
// Depends on lcet_pkg, lcet_ctrl and lcet_datapath.
`default_nettype none
// Keeps the upper (or, with min_mode set, lower) envelope of inserted lines
// over a loaded table of ascending coordinates. An insert walks the tree
// one level at a time; each level takes three coordinate reads, six
// evaluations through the single 32x32 multiplier and one decision. A query
// walks the tree one level at a time as well, and its result sits in an
// output register. After reset and after each clear request the node memory
// is swept, during which no request is taken.
module li_chao_line_envelope_tree #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output      logic                           req_ready,
  input  wire lcet_pkg::lcet_req_t            req,
  output      logic                           rsp_valid,
  input  wire logic                           rsp_ready,
  output      lcet_pkg::lcet_rsp_t            rsp,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [lcet_pkg::CFG_WIDTH-1:0] cfg_data
);
  import lcet_pkg::*;

  lcet_cmd_t cmd;
  lcet_sts_t sts;

  lcet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .opcode    (req.opcode),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcet_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[rtl/lcet_ctrl.sv]
// Sequencer for the line envelope tree: clearing pass, insert and query descent.
// Depends on lcet_pkg; drives the datapath through lcet_cmd_t.
`default_nettype none
module lcet_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic [1:0]         opcode,
  output      logic               req_ready,
  input  wire lcet_pkg::lcet_sts_t sts,
  output      lcet_pkg::lcet_cmd_t cmd
);
  import lcet_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_IRN  = 4'd2;
  localparam logic [3:0] S_IRR  = 4'd3;
  localparam logic [3:0] S_IRM  = 4'd4;
  localparam logic [3:0] S_IEV  = 4'd5;
  localparam logic [3:0] S_IDEC = 4'd6;
  localparam logic [3:0] S_QRN  = 4'd7;
  localparam logic [3:0] S_QMUL = 4'd8;
  localparam logic [3:0] S_QADD = 4'd9;
  localparam logic [3:0] S_QOUT = 4'd10;

  logic [3:0] state, state_next;
  logic [2:0] ev, ev_next;

  // Advance state and evaluation step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ev    <= '0;
    end else begin
      state <= state_next;
      ev    <= ev_next;
    end
  end

  // Decode state into datapath commands
  always_comb begin
    state_next = state;
    ev_next    = ev;
    cmd        = '0;
    cmd.ev     = ev;
    req_ready  = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (opcode)
            OP_LOAD:   cmd.load_coord = 1'b1;
            OP_INSERT: begin
              cmd.init   = 1'b1;
              state_next = S_IRN;
            end
            OP_QUERY: begin
              cmd.init   = 1'b1;
              state_next = S_QRN;
            end
            default:   state_next = S_CLR;
          endcase
        end
      end
      S_IRN: begin
        cmd.rd_node   = 1'b1;
        cmd.rd_coord  = 1'b1;
        cmd.coord_sel = CSEL_LO;
        state_next    = S_IRR;
      end
      S_IRR: begin
        if (!sts.used) begin
          cmd.put_new = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.latch_t   = 1'b1;
          cmd.rd_coord  = 1'b1;
          cmd.coord_sel = CSEL_HI;
          state_next    = S_IRM;
        end
      end
      S_IRM: begin
        cmd.latch_xr  = 1'b1;
        cmd.rd_coord  = 1'b1;
        cmd.coord_sel = CSEL_MID;
        ev_next       = '0;
        state_next    = S_IEV;
      end
      S_IEV: begin
        cmd.latch_xm = (ev == 3'd0);
        cmd.mul_en   = (ev != EV_LAST);
        cmd.add_en   = (ev != 3'd0);
        ev_next      = ev + 3'd1;
        if (ev == EV_LAST) state_next = S_IDEC;
      end
      S_IDEC: begin
        cmd.decide = 1'b1;
        state_next = sts.ins_stop ? S_IDLE : S_IRN;
      end
      S_QRN: begin
        cmd.rd_node   = 1'b1;
        cmd.rd_coord  = 1'b1;
        cmd.coord_sel = CSEL_MID;
        state_next    = S_QMUL;
      end
      S_QMUL: begin
        if (!sts.used) begin
          state_next = S_QOUT;
        end else begin
          cmd.q_mul    = 1'b1;
          cmd.latch_xm = 1'b1;
          state_next   = S_QADD;
        end
      end
      S_QADD: begin
        cmd.q_acc  = 1'b1;
        state_next = sts.q_stop ? S_QOUT : S_QRN;
      end
      S_QOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

[rtl/lcet_datapath.sv]
// Datapath: node and coordinate memories, shared multiply-add, descent registers.
// Depends on lcet_pkg; driven by lcet_ctrl through lcet_cmd_t.
`default_nettype none
module lcet_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lcet_pkg::lcet_req_t         req,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [lcet_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire lcet_pkg::lcet_cmd_t         cmd,
  output      lcet_pkg::lcet_sts_t         sts,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_ready,
  output      lcet_pkg::lcet_rsp_t         rsp
);
  import lcet_pkg::*;

  localparam int NODES = 4 * MAX_POINTS;
  localparam int CW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW    = $clog2(NODES);

  function automatic logic better(input logic signed [63:0] p, input logic signed [63:0] q,
                                  input logic mm);
    return mm ? (p < q) : (p > q);
  endfunction

  // Configuration
  logic        min_mode;
  logic [10:0] point_count;

  // Memories and their read registers
  logic [80:0]        node_mem [NODES];
  logic signed [31:0] coord_mem [MAX_POINTS];
  logic [80:0]        node_rd;
  logic signed [31:0] coord_rd;

  // Descent state
  logic [CW-1:0]      lo, hi;
  logic [NW:0]        idx;
  logic signed [31:0] v_slope, t_slope, qx, xl, xr, xm;
  logic signed [47:0] v_icpt, t_icpt;
  logic signed [63:0] prod, best;
  logic signed [63:0] vals [6];
  logic               found;
  logic [NW-1:0]      clr_addr;

  // Combinational helpers
  logic [20:0]        pc_ext, eff;
  logic [CW-1:0]      hi0, mid, coord_ra;
  logic [20:0]        slot;
  logic [NW:0]        child_l, child_r;
  logic               bl, br, go_right, q_left, lo_ge_hi;
  logic signed [31:0] big_t_s, big_v_s, mul_a, mul_b;
  logic signed [47:0] big_t_i, big_v_i, add_i;
  logic signed [63:0] m_t, m_v, sum;
  logic [2:0]         ji;
  logic               node_we;
  logic [NW-1:0]      node_wa;
  logic [80:0]        node_wd;

  assign pc_ext   = 21'(point_count);
  assign eff      = (pc_ext == 21'd0) ? 21'd1 :
                    (pc_ext > 21'(MAX_POINTS)) ? 21'(MAX_POINTS) : pc_ext;
  assign hi0      = CW'(eff - 21'd1);
  assign mid      = CW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign slot     = 21'(req.point_index);
  assign lo_ge_hi = (lo >= hi);
  assign child_l  = (NW+1)'({idx[NW-1:0], 1'b0}) + (NW+1)'(1);
  assign child_r  = (NW+1)'({idx[NW-1:0], 1'b0}) + (NW+1)'(2);

  // Insert decision from the six evaluated values
  assign bl       = better(vals[2], vals[0], min_mode);
  assign br       = better(vals[3], vals[1], min_mode);
  assign big_t_s  = bl ? v_slope : t_slope;
  assign big_t_i  = bl ? v_icpt  : t_icpt;
  assign big_v_s  = bl ? t_slope : v_slope;
  assign big_v_i  = bl ? t_icpt  : v_icpt;
  assign m_t      = bl ? vals[5] : vals[4];
  assign m_v      = bl ? vals[4] : vals[5];
  assign go_right = better(m_t, m_v, min_mode);
  assign q_left   = (xm >= qx);

  always_comb begin
    sts.used     = node_rd[80];
    sts.clr_last = (clr_addr == NW'(NODES - 1));
    sts.ins_stop = (bl == br) || lo_ge_hi ||
                   ((go_right ? child_r : child_l) >= (NW+1)'(NODES));
    sts.q_stop   = lo_ge_hi || ((q_left ? child_l : child_r) >= (NW+1)'(NODES));
    sts.out_free = !rsp_valid || rsp_ready;
  end

  // Select multiplier operands
  always_comb begin
    mul_a = t_slope;
    mul_b = xl;
    if (cmd.q_mul) begin
      mul_a = node_rd[79:48];
      mul_b = qx;
    end else begin
      case (cmd.ev)
        3'd0: begin mul_a = t_slope; mul_b = xl; end
        3'd1: begin mul_a = t_slope; mul_b = xr; end
        3'd2: begin mul_a = v_slope; mul_b = xl; end
        3'd3: begin mul_a = v_slope; mul_b = xr; end
        3'd4: begin mul_a = t_slope; mul_b = xm; end
        default: begin mul_a = v_slope; mul_b = xm; end
      endcase
    end
  end

  // Select the intercept that goes with the last product
  assign ji = cmd.ev - 3'd1;
  always_comb begin
    if (cmd.q_acc) add_i = node_rd[47:0];
    else if (ji inside {3'd0, 3'd1, 3'd4}) add_i = t_icpt;
    else add_i = v_icpt;
  end
  assign sum = prod + {{16{add_i[47]}}, add_i};

  // Coordinate read address
  always_comb begin
    case (cmd.coord_sel)
      CSEL_LO: coord_ra = lo;
      CSEL_HI: coord_ra = hi;
      default: coord_ra = mid;
    endcase
  end

  // Node write port: clearing pass, fresh node, or descent update
  always_comb begin
    node_we = 1'b0;
    node_wa = idx[NW-1:0];
    node_wd = '0;
    if (cmd.clr_wr) begin
      node_we = 1'b1;
      node_wa = clr_addr;
    end else if (cmd.put_new) begin
      node_we = 1'b1;
      node_wd = {1'b1, v_slope, v_icpt};
    end else if (cmd.decide) begin
      if (bl && br) begin
        node_we = 1'b1;
        node_wd = {1'b1, v_slope, v_icpt};
      end else if ((bl || br) && !lo_ge_hi) begin
        node_we = 1'b1;
        node_wd = go_right ? {1'b1, big_t_s, big_t_i} : {1'b1, big_v_s, big_v_i};
      end
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (cmd.rd_node) node_rd <= node_mem[idx[NW-1:0]];
    if (cmd.load_coord && slot < 21'(MAX_POINTS)) coord_mem[slot[CW-1:0]] <= req.point_value;
    if (cmd.rd_coord) coord_rd <= coord_mem[coord_ra];
  end

  // Configuration, clear counter and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_mode    <= 1'b0;
      point_count <= 11'd1;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_MIN_MODE) min_mode <= cfg_data[0];
      if (cfg_we && cfg_index == REG_POINT_COUNT) point_count <= cfg_data;
      if (cmd.clr_wr) clr_addr <= sts.clr_last ? '0 : clr_addr + NW'(1);
      if (cmd.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.envelope_value <= best;
      rsp.line_present   <= found;
    end
  end

  // Descent registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo      <= '0;
      hi      <= hi0;
      idx     <= '0;
      v_slope <= req.slope;
      v_icpt  <= req.intercept;
      qx      <= req.query_point;
      found   <= 1'b0;
      best    <= '0;
    end
    if (cmd.latch_t) begin
      t_slope <= node_rd[79:48];
      t_icpt  <= node_rd[47:0];
      xl      <= coord_rd;
    end
    if (cmd.latch_xr) xr <= coord_rd;
    if (cmd.latch_xm) xm <= coord_rd;
    if (cmd.mul_en || cmd.q_mul) prod <= mul_a * mul_b;
    if (cmd.add_en) vals[ji] <= sum;
    if (cmd.decide && (bl != br) && !lo_ge_hi) begin
      if (go_right) begin
        v_slope <= big_v_s;
        v_icpt  <= big_v_i;
        lo      <= mid + CW'(1);
        idx     <= child_r;
      end else begin
        v_slope <= big_t_s;
        v_icpt  <= big_t_i;
        hi      <= mid;
        idx     <= child_l;
      end
    end
    if (cmd.q_acc) begin
      if (!found || better(sum, best, min_mode)) best <= sum;
      found <= 1'b1;
      if (!lo_ge_hi) begin
        if (q_left) begin
          hi  <= mid;
          idx <= child_l;
        end else begin
          lo  <= mid + CW'(1);
          idx <= child_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

[tb/li_chao_line_envelope_tree_test.sv]
// Self-checking testbench for the Li Chao line envelope tree.
// Depends on lcet_pkg and li_chao_line_envelope_tree; predicts every query answer.
`timescale 1ns / 1ps
`default_nettype none
module li_chao_line_envelope_tree_test;
  import lcet_pkg::*;

  localparam int MAXP      = 1024;
  localparam int NODES     = 4 * MAXP;
  localparam int DOG_LIMIT = 20000;
  localparam int SETTLE    = NODES + 200;

  typedef struct {
    logic [1:0]          op;
    logic [9:0]          slot;
    logic signed [31:0]  pval;
    logic signed [31:0]  k;
    logic signed [47:0]  b;
    logic signed [31:0]  x;
    bit                  typed;
    logic signed [63:0]  want_val;
    logic                want_hit;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  lcet_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lcet_rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  li_chao_line_envelope_tree i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the envelope tree
  logic signed [31:0] tree_k [NODES];
  logic signed [47:0] tree_b [NODES];
  bit                 tree_used [NODES];
  logic signed [31:0] coords [MAXP];
  bit                 min_env;
  int                 pcount;

  lcet_rsp_t answers [$];
  int errors = 0;
  int dog = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;

  function automatic logic signed [63:0] line_at(logic signed [31:0] k,
      logic signed [47:0] b, logic signed [31:0] x);
    logic signed [63:0] p;
    p = 64'(k) * 64'(x);
    return p + 64'(b);
  endfunction

  function automatic bit wins(logic signed [63:0] p, logic signed [63:0] q);
    return min_env ? (p < q) : (p > q);
  endfunction

  function automatic int span();
    int n;
    n = pcount;
    if (n == 0) n = 1;
    if (n > MAXP) n = MAXP;
    return n;
  endfunction

  function automatic void shadow_insert(logic signed [31:0] vk, logic signed [47:0] vb);
    int lo, hi, idx, mid;
    logic signed [31:0] tk;
    logic signed [47:0] tb;
    logic signed [63:0] tl, tr, vl, vr;
    lo = 0; hi = span() - 1; idx = 0;
    while (idx < NODES) begin
      if (!tree_used[idx]) begin
        tree_k[idx] = vk; tree_b[idx] = vb; tree_used[idx] = 1'b1;
        return;
      end
      tk = tree_k[idx]; tb = tree_b[idx];
      tl = line_at(tk, tb, coords[lo]); tr = line_at(tk, tb, coords[hi]);
      vl = line_at(vk, vb, coords[lo]); vr = line_at(vk, vb, coords[hi]);
      if (!wins(vl, tl) && !wins(vr, tr)) return;
      if (wins(vl, tl) && wins(vr, tr)) begin
        tree_k[idx] = vk; tree_b[idx] = vb;
        return;
      end
      if (lo >= hi) return;
      mid = (lo + hi) >> 1;
      // keep the line that wins on the left in t
      if (wins(vl, tl)) begin
        {tk, vk} = {vk, tk}; {tb, vb} = {vb, tb};
      end
      if (wins(line_at(tk, tb, coords[mid]), line_at(vk, vb, coords[mid]))) begin
        tree_k[idx] = tk; tree_b[idx] = tb;
        lo = mid + 1; idx = 2 * idx + 2;
      end else begin
        tree_k[idx] = vk; tree_b[idx] = vb;
        vk = tk; vb = tb;
        hi = mid; idx = 2 * idx + 1;
      end
    end
  endfunction

  function automatic lcet_rsp_t best_at(logic signed [31:0] x);
    lcet_rsp_t r;
    int lo, hi, idx, mid;
    logic signed [63:0] y;
    r = '0; lo = 0; hi = span() - 1; idx = 0;
    while (idx < NODES && tree_used[idx]) begin
      y = line_at(tree_k[idx], tree_b[idx], x);
      if (!r.line_present || wins(y, r.envelope_value)) r.envelope_value = y;
      r.line_present = 1'b1;
      if (lo >= hi) break;
      mid = (lo + hi) >> 1;
      if (coords[mid] >= x) begin
        hi = mid; idx = 2 * idx + 1;
      end else begin
        lo = mid + 1; idx = 2 * idx + 2;
      end
    end
    return r;
  endfunction

  // Apply an accepted request to the shadow tree
  function automatic void apply_request(lcet_req_t q);
    case (q.opcode)
      OP_LOAD:   coords[q.point_index] = q.point_value;
      OP_INSERT: shadow_insert(q.slope, q.intercept);
      OP_QUERY:  answers.push_back(best_at(q.query_point));
      default:   foreach (tree_used[i]) tree_used[i] = 1'b0;
    endcase
  endfunction

  // Check results, and run a watchdog that restarts on every request or result handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d/%0d", rsp.envelope_value,
                                     rsp.line_present);
        end else begin
          if (rsp.envelope_value !== answers[0].envelope_value ||
              rsp.line_present !== answers[0].line_present) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d/%0d got %0d/%0d",
                       answers[0].envelope_value, answers[0].line_present,
                       rsp.envelope_value, rsp.line_present);
          end
          void'(answers.pop_front());
        end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) dog <= 0;
      else dog <= dog + 1;
    end
  end

  always @(posedge clk) begin
    if (dog >= DOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and wait for it to be taken, idling at random first;
  // valid stays high until the next request or a drain drops it
  task automatic send(lcet_req_t q);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_request(q);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [CFG_WIDTH-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MIN_MODE) min_env = v[0];
    else pcount = int'(v);
  endtask

  function automatic lcet_req_t pack_row(row_t r);
    lcet_req_t q;
    q.opcode = r.op; q.point_index = r.slot; q.point_value = r.pval;
    q.slope = r.k; q.intercept = r.b; q.query_point = r.x;
    return q;
  endfunction

  function automatic lcet_req_t noise();
    lcet_req_t q;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(lcet_req_t)-1:0];
    return q;
  endfunction

  // Load n sorted distinct coordinates, spread over the full range sometimes
  task automatic load_table(int n, bit wide);
    lcet_req_t q;
    logic signed [31:0] v;
    int step;
    step = wide ? 32'h7fffffff / n * 2 : $urandom_range(1, 50);
    v = wide ? 32'sh80000000 : -$signed(32'($urandom_range(0, 2000)));
    for (int i = 0; i < n; i++) begin
      q = noise();
      q.opcode = OP_LOAD; q.point_index = 10'(i); q.point_value = v;
      send(q);
      if (i == n - 2 && wide) v = 32'sh7fffffff;
      else v = v + $urandom_range(1, step);
    end
  endtask

  // Mostly inserts and queries at loaded points, with some clears and noise
  task automatic random_mix(int count, int n);
    lcet_req_t q;
    int pick;
    for (int i = 0; i < count; i++) begin
      q = noise();
      pick = $urandom_range(0, 99);
      if (pick < 40) q.opcode = OP_INSERT;
      else if (pick < 90) begin
        q.opcode = OP_QUERY;
        if ($urandom_range(0, 3) != 0) q.query_point = coords[$urandom_range(0, n - 1)];
      end else if (pick < 93) q.opcode = OP_CLEAR;
      else begin
        q.opcode = OP_LOAD;
        q.point_index = 10'($urandom_range(n, MAXP - 1) % MAXP);
        if (q.point_index < n) q.opcode = OP_QUERY;
      end
      if (q.opcode == OP_INSERT && $urandom_range(0, 1)) begin
        q.slope = $signed(32'($urandom_range(0, 200))) - 100;
        q.intercept = $signed(48'($urandom_range(0, 20000))) - 10000;
      end
      send(q);
    end
  endtask

  row_t plan [$];

  initial begin : stimulus
    row_t r;
    lcet_req_t q;
    lcet_rsp_t got;
    foreach (coords[i]) coords[i] = '0;
    foreach (tree_used[i]) tree_used[i] = 1'b0;
    min_env = 1'b0; pcount = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty query, extremes, every operation, ties, clear
    set_reg(REG_POINT_COUNT, 11'd2);
    r = '{OP_QUERY, 0, 0, 0, 0, 5, 1'b1, 64'sd0, 1'b0};                      plan.push_back(r);
    r = '{OP_LOAD, 10'd0, 32'sh80000000, 0, 0, 0, 1'b0, 0, 0};               plan.push_back(r);
    r = '{OP_LOAD, 10'd1, 32'sh7fffffff, 0, 0, 0, 1'b0, 0, 0};               plan.push_back(r);
    r = '{OP_LOAD, 10'd1023, 32'sh7fffffff, 0, 0, 0, 1'b0, 0, 0};            plan.push_back(r);
    r = '{OP_INSERT, 0, 0, 32'sh80000000, 48'sh800000000000, 0, 1'b0, 0, 0}; plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 32'sh80000000, 1'b1,
          64'sh4000000000000000 - 64'sh0000800000000000, 1'b1};                plan.push_back(r);
    r = '{OP_INSERT, 0, 0, 32'sh7fffffff, 48'sh7fffffffffff, 0, 1'b0, 0, 0}; plan.push_back(r);
    r = '{OP_INSERT, 0, 0, 32'sh7fffffff, 48'sh7fffffffffff, 0, 1'b0, 0, 0}; plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 32'sh7fffffff, 1'b0, 0, 0};                  plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 32'sh80000000, 1'b0, 0, 0};                  plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 0, 1'b0, 0, 0};                              plan.push_back(r);
    r = '{OP_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0, 0};                              plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 32'sh7fffffff, 1'b1, 64'sd0, 1'b0};          plan.push_back(r);
    r = '{OP_INSERT, 0, 0, 0, 48'sd7, 0, 1'b0, 0, 0};                        plan.push_back(r);
    r = '{OP_QUERY, 0, 0, 0, 0, 32'sd3, 1'b1, 64'sd7, 1'b1};                 plan.push_back(r);
    foreach (plan[i]) begin
      q = pack_row(plan[i]);
      send(q);
      // rows with a typed answer replace the predicted one
      if (plan[i].typed) begin
        got.envelope_value = plan[i].want_val;
        got.line_present = plan[i].want_hit;
        answers[answers.size() - 1] = got;
      end
    end
    drain();

    // Minimum mode and the zero count case
    set_reg(REG_MIN_MODE, 11'd1);
    set_reg(REG_POINT_COUNT, 11'd0);
    random_mix(15, 1);
    drain();

    // Minimum mode over a table spread across the full coordinate range
    set_reg(REG_POINT_COUNT, 11'd32);
    load_table(32, 1'b1);
    random_mix(30, 32);
    drain();

    // Maximum mode, small table; stall the receiver long while requests pile in
    set_reg(REG_MIN_MODE, 11'd0);
    set_reg(REG_POINT_COUNT, 11'd16);
    load_table(16, 1'b0);
    hold_long = 1'b1;
    random_mix(60, 16);
    drain();

    // Unsorted table and minimum mode over a medium count
    set_reg(REG_MIN_MODE, 11'd1);
    set_reg(REG_POINT_COUNT, 11'd40);
    load_table(40, 1'b0);
    q = noise(); q.opcode = OP_LOAD; q.point_index = 7; send(q);
    random_mix(80, 40);
    drain();

    set_reg(REG_MIN_MODE, 11'd0);
    set_reg(REG_POINT_COUNT, 11'd48);
    load_table(48, 1'b1);
    random_mix(40, 48);
    calm = 1'b1;
    random_mix(40, 48);

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
